### rtl/core/mtbb_pkg.sv
`timescale 1ns / 1ps

package mtbb_pkg;

  // input selector codes
  localparam logic [1:0] FUNC_REQUEST = 2'd0;
  localparam logic [1:0] FUNC_NOTIFY  = 2'd1;
  localparam logic [1:0] FUNC_DRAIN   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_LINK   = 2'd0;
  localparam logic [1:0] KIND_REPLY  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [1:0] ST_READY       = 2'd0;
  localparam logic [1:0] ST_LEN_RETRY   = 2'd1;
  localparam logic [1:0] ST_LEN_CLOSE   = 2'd2;
  localparam logic [1:0] ST_WRITE_CLOSE = 2'd3;

  // notify buffer
  localparam int NOTIFY_DEPTH = 256;
  localparam int NOTIFY_AW    = $clog2(NOTIFY_DEPTH);
  localparam logic [8:0] NOTIFY_MAX = 9'd511;

  localparam logic [2:0] ERROR_LIMIT = 3'd5;
  localparam logic [2:0] ERRORS_MAX  = 3'd7;

  // request framing
  localparam logic [3:0]  REQ_MIN   = 4'd12;
  localparam int          FRAME_LEN = 13;
  localparam logic [3:0]  FRAME_LAST = 4'd12;
  localparam logic [3:0]  CRC_START = 4'd6;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  LINK_PREFIX_HI = 8'd77;
  localparam logic [7:0]  LINK_PREFIX_LO = 8'd0;
  localparam logic [7:0]  LINK_CMD  = 8'd9;
  localparam logic [7:0]  LINK_OP   = 8'd50;
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'd6;

  // reply layout
  localparam int          HEADER_LEN     = 8;
  localparam logic [9:0]  REPLY_OVERHEAD = 10'd9;
  localparam logic [17:0] NOTIFY_OFFSET  = 18'd7;
  localparam logic [16:0] LEN_EXTRA      = 17'd3;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### rtl/core/mtbb_ram.sv
`timescale 1ns / 1ps

module mtbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/modbus_tcp_to_ble_frame_bridge.sv
`timescale 1ns / 1ps

// Modbus TCP to link bridge. Request, notify and drain-tick items are taken one per
// cycle unless the input stalls. The final byte of a valid request (12 bytes or more,
// no reply outstanding) produces a 13-byte link request that leaves the emit stage one
// byte per cycle unless the output stalls; the input stalls while the first twelve
// bytes move on, and the next item is taken as the last byte moves on. The final
// notify byte produces one status result; each drain tick while a reply is pending
// produces one reply byte, from the reply header or past it from the notify buffer
// RAM (registered read, which lines up with the emit stage). Every result passes the
// emit stage, then the output register; items with at most one result sustain one per
// cycle when the output is not stalled. No clearing pass is needed after reset.
module modbus_tcp_to_ble_frame_bridge (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] byte_out,
  output logic       run_end,
  output logic [1:0] status_code
);

  // request side
  logic [7:0]  request_store [12];
  logic [3:0]  request_count;
  logic [15:0] crc_accum;
  logic [7:0]  sequence_number;
  logic        awaiting_reply;
  logic [16:0] expected_length;
  logic [7:0]  reply_header [mtbb_pkg::HEADER_LEN];
  // notify side
  logic [2:0]  length_errors;
  logic [8:0]  notify_count;
  logic [8:0]  drain_position;
  logic        drain_pending;
  logic [7:0]  notify_byte7;

  // emit stage
  logic        p_valid;
  logic [1:0]  p_kind;
  logic        p_from_ram;
  logic [7:0]  p_byte;
  logic        p_end;
  logic [1:0]  p_status;
  logic [7:0]  p_frame [mtbb_pkg::FRAME_LEN];
  logic [3:0]  p_idx;

  logic        accept;
  logic        is_req;
  logic        is_notify;
  logic        is_drain;
  logic        o_load;
  logic        p_done;
  logic        p_load;

  logic [7:0]  req_view [12];
  logic [15:0] crc_cur;
  logic [15:0] crc_new;
  logic [3:0]  req_count_inc;
  logic        req_ok;
  logic [16:0] exp_new;

  logic [8:0]  notify_inc;
  logic        len_mismatch;
  logic [2:0]  errors_inc;
  logic [1:0]  notify_status;
  logic        notify_store_en;

  logic [9:0]  reply_total;
  logic        drain_end;
  logic [17:0] stored_len;
  logic [17:0] lim;
  logic [17:0] idx_raw;
  logic [17:0] idx;
  logic        drain_from_ram;
  logic [7:0]  ram_rdata;

  logic [1:0]  e_kind;
  logic [7:0]  e_byte;
  logic        e_end;
  logic [1:0]  e_status;

  assign is_req    = (func == mtbb_pkg::FUNC_REQUEST);
  assign is_notify = (func == mtbb_pkg::FUNC_NOTIFY);
  assign is_drain  = (func == mtbb_pkg::FUNC_DRAIN);

  assign o_load   = p_valid && (!out_valid || !out_stall);
  assign p_done   = o_load && (p_kind != mtbb_pkg::KIND_LINK || p_idx == mtbb_pkg::FRAME_LAST);
  assign in_stall = p_valid && !p_done;
  assign accept   = in_valid && !in_stall;

  // request view with the incoming byte already in place
  always_comb begin
    for (int i = 0; i < 12; i++) begin
      req_view[i] = (request_count == 4'(i)) ? data_byte : request_store[i];
    end
    crc_cur = (request_count == 4'd0) ? mtbb_pkg::CRC_INIT : crc_accum;
    if (request_count >= mtbb_pkg::CRC_START && request_count < mtbb_pkg::REQ_MIN) begin
      crc_new = mtbb_pkg::crc_step(crc_cur, data_byte);
    end else begin
      crc_new = crc_cur;
    end
    req_count_inc = (request_count < mtbb_pkg::REQ_MIN) ? request_count + 4'd1
                                                        : request_count;
    req_ok  = (req_count_inc == mtbb_pkg::REQ_MIN) && !awaiting_reply;
    exp_new = {req_view[10], req_view[11], 1'b0} + mtbb_pkg::LEN_EXTRA;
  end

  // notify end decision
  always_comb begin
    notify_inc   = (notify_count < mtbb_pkg::NOTIFY_MAX) ? notify_count + 9'd1 : notify_count;
    len_mismatch = (18'(notify_inc) != 18'(expected_length) + mtbb_pkg::NOTIFY_OFFSET);
    errors_inc   = (length_errors < mtbb_pkg::ERRORS_MAX) ? length_errors + 3'd1
                                                          : length_errors;
    if (reply_header[7] == mtbb_pkg::FUNC_WRITE_SINGLE) begin
      notify_status = mtbb_pkg::ST_WRITE_CLOSE;
    end else if (len_mismatch) begin
      notify_status = (errors_inc > mtbb_pkg::ERROR_LIMIT) ? mtbb_pkg::ST_LEN_CLOSE
                                                           : mtbb_pkg::ST_LEN_RETRY;
    end else begin
      notify_status = mtbb_pkg::ST_READY;
    end
    notify_store_en = accept && is_notify &&
                      (18'(notify_count) < 18'(mtbb_pkg::NOTIFY_DEPTH));
  end

  // drain addressing; clamp reads past the received bytes
  always_comb begin
    reply_total    = mtbb_pkg::REPLY_OVERHEAD + 10'(notify_byte7);
    drain_end      = (10'(drain_position) + 10'd1 >= reply_total);
    stored_len     = 18'(expected_length) + mtbb_pkg::NOTIFY_OFFSET;
    lim            = (stored_len < 18'(mtbb_pkg::NOTIFY_DEPTH)) ? stored_len
                                                                : 18'(mtbb_pkg::NOTIFY_DEPTH);
    idx_raw        = 18'(drain_position) - 18'd1;
    idx            = (idx_raw >= lim) ? lim - 18'd1 : idx_raw;
    drain_from_ram = (drain_position >= 9'(mtbb_pkg::HEADER_LEN));
  end

  assign p_load = accept && ((is_req && is_last && req_ok) || (is_notify && is_last) ||
                             (is_drain && drain_pending));

  mtbb_ram #(
    .WIDTH (8),
    .DEPTH (mtbb_pkg::NOTIFY_DEPTH)
  ) u_notify_ram (
    .clk   (clk),
    .we    (notify_store_en),
    .waddr (notify_count[mtbb_pkg::NOTIFY_AW-1:0]),
    .wdata (data_byte),
    .re    (accept && is_drain && drain_pending && drain_from_ram),
    .raddr (idx[mtbb_pkg::NOTIFY_AW-1:0]),
    .rdata (ram_rdata)
  );

  // bridge state
  always_ff @(posedge clk) begin
    if (rst) begin
      request_count   <= 4'd0;
      crc_accum       <= mtbb_pkg::CRC_INIT;
      sequence_number <= 8'd0;
      awaiting_reply  <= 1'b0;
      expected_length <= 17'd0;
      for (int i = 0; i < mtbb_pkg::HEADER_LEN; i++) begin
        reply_header[i] <= 8'd0;
      end
      length_errors  <= 3'd0;
      notify_count   <= 9'd0;
      drain_position <= 9'd0;
      drain_pending  <= 1'b0;
    end else if (accept) begin
      if (is_req) begin
        if (request_count < mtbb_pkg::REQ_MIN) begin
          request_store[request_count] <= data_byte;
        end
        if (!is_last) begin
          request_count <= req_count_inc;
          crc_accum     <= crc_new;
        end else begin
          request_count <= 4'd0;
          crc_accum     <= mtbb_pkg::CRC_INIT;
          if (req_ok) begin
            expected_length <= exp_new;
            for (int i = 0; i < 4; i++) begin
              reply_header[i] <= req_view[i];
            end
            reply_header[4] <= exp_new[15:8];
            reply_header[5] <= exp_new[7:0];
            reply_header[6] <= req_view[6];
            reply_header[7] <= req_view[7];
            sequence_number <= sequence_number + 8'd1;
            awaiting_reply  <= 1'b1;
            drain_pending   <= 1'b0;
          end
        end
      end else if (is_notify) begin
        drain_pending <= 1'b0;
        if (notify_count == 9'd7) begin
          notify_byte7 <= data_byte;
        end
        if (!is_last) begin
          notify_count <= notify_inc;
        end else begin
          awaiting_reply <= 1'b0;
          notify_count   <= 9'd0;
          if (reply_header[7] != mtbb_pkg::FUNC_WRITE_SINGLE) begin
            if (len_mismatch) begin
              length_errors <= errors_inc;
            end else begin
              length_errors  <= 3'd0;
              drain_pending  <= 1'b1;
              drain_position <= 9'd0;
            end
          end
        end
      end else if (is_drain && drain_pending) begin
        if (drain_end) begin
          drain_pending  <= 1'b0;
          drain_position <= 9'd0;
        end else begin
          drain_position <= drain_position + 9'd1;
        end
      end
    end
  end

  // emit stage: holds one pending result or a whole link frame
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_idx   <= 4'd0;
    end else if (p_load) begin
      p_valid <= 1'b1;
      p_idx   <= 4'd0;
    end else begin
      if (p_done) begin
        p_valid <= 1'b0;
      end
      if (o_load && p_kind == mtbb_pkg::KIND_LINK) begin
        p_idx <= p_idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_load) begin
      p_from_ram <= 1'b0;
      p_byte     <= 8'd0;
      p_end      <= 1'b1;
      p_status   <= mtbb_pkg::ST_READY;
      if (is_req) begin
        p_kind      <= mtbb_pkg::KIND_LINK;
        p_frame[0]  <= mtbb_pkg::LINK_PREFIX_HI;
        p_frame[1]  <= mtbb_pkg::LINK_PREFIX_LO;
        p_frame[2]  <= sequence_number;
        p_frame[3]  <= mtbb_pkg::LINK_CMD;
        p_frame[4]  <= mtbb_pkg::LINK_OP;
        for (int i = 0; i < 6; i++) begin
          p_frame[5 + i] <= req_view[6 + i];
        end
        p_frame[11] <= crc_new[7:0];
        p_frame[12] <= crc_new[15:8];
      end else if (is_notify) begin
        p_kind   <= mtbb_pkg::KIND_STATUS;
        p_status <= notify_status;
      end else begin
        p_kind     <= mtbb_pkg::KIND_REPLY;
        p_from_ram <= drain_from_ram;
        p_byte     <= reply_header[drain_position[2:0]];
        p_end      <= drain_end;
      end
    end
  end

  always_comb begin
    e_kind   = p_kind;
    e_byte   = p_byte;
    e_end    = p_end;
    e_status = p_status;
    case (p_kind)
      mtbb_pkg::KIND_LINK: begin
        e_byte   = p_frame[p_idx];
        e_end    = (p_idx == mtbb_pkg::FRAME_LAST);
        e_status = mtbb_pkg::ST_READY;
      end
      mtbb_pkg::KIND_REPLY: begin
        e_byte = p_from_ram ? ram_rdata : p_byte;
      end
      default: begin
        e_byte = 8'd0;
        e_end  = 1'b1;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      kind        <= e_kind;
      byte_out    <= e_byte;
      run_end     <= e_end;
      status_code <= e_status;
    end
  end

endmodule

### rtl/core/mtbb_checker.sv
`timescale 1ns / 1ps

module mtbb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [7:0] byte_out,
  input logic       run_end,
  input logic [1:0] status_code
);

  // reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a status result carries no byte and always closes its run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == mtbb_pkg::KIND_STATUS |-> byte_out == 8'd0 && run_end)
    else $error("malformed status result");

  // frame bytes carry no status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != mtbb_pkg::KIND_STATUS |-> status_code == mtbb_pkg::ST_READY)
    else $error("status code on a frame byte");

  // a link frame stalled mid-way blocks the next request
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall && kind == mtbb_pkg::KIND_LINK && !run_end |-> in_stall)
    else $error("input taken while a link frame is stalled");

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(byte_out) && $stable(kind))
    else $error("stalled result changed");

endmodule

bind modbus_tcp_to_ble_frame_bridge mtbb_checker u_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] func;
    logic [7:0] data;
    logic       last;
    bit         hold;
  } bridge_req_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } bridge_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = mtbb_pkg::FUNC_REQUEST;
  logic [7:0] data_byte = 8'h00;
  logic       is_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] byte_out;
  logic       run_end;
  logic [1:0] status_code;

  modbus_tcp_to_ble_frame_bridge i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .data_byte  (data_byte),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .byte_out   (byte_out),
    .run_end    (run_end),
    .status_code(status_code)
  );

  bridge_req_t    pending_reqs[$];
  bridge_result_t expected_outputs[$];
  bridge_req_t    cur_req;
  bridge_result_t got_want;
  bit             req_taken = 1'b0;
  int             cyc = 0;
  int             queued_items = 0;
  int             items_taken = 0;
  int             errors = 0;
  int             link_bytes = 0;
  int             reply_bytes = 0;
  int             status_seen[4] = '{default: 0};

  wire quiet = (cyc >= 120 && cyc < 320);

  // bridge state as the predictor sees it
  logic [7:0]  req_bytes [12];
  logic [3:0]  req_cnt = 4'd0;
  logic [15:0] crc = mtbb_pkg::CRC_INIT;
  logic [7:0]  seq = 8'd0;
  bit          waiting = 1'b0;
  logic [16:0] exp_len = 17'd0;
  logic [7:0]  hdr [8] = '{default: 8'h00};
  logic [2:0]  len_err = 3'd0;
  logic [7:0]  ntf [mtbb_pkg::NOTIFY_DEPTH];
  logic [8:0]  ntf_cnt = 9'd0;
  logic [8:0]  drain_pos = 9'd0;
  bit          drain_on = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] modbus_crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    acc = c ^ {8'h00, b};
    repeat (8) begin
      if (acc[0]) acc = (acc >> 1) ^ mtbb_pkg::CRC_POLY;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  task automatic push_result(input logic [1:0] k, input logic [7:0] b, input logic e,
                             input logic [1:0] st);
    bridge_result_t res;
    res.kind = k;
    res.data = b;
    res.last = e;
    res.status = st;
    expected_outputs.insert(expected_outputs.size(), res);
  endtask

  task automatic predict_outputs(input bridge_req_t r);
    logic [7:0]  frame [13];
    logic [15:0] regs;
    logic [1:0]  st;
    logic [7:0]  v;
    int          stored;
    int          lim;
    int          total;
    int          idx;
    case (r.func)
      mtbb_pkg::FUNC_REQUEST: begin
        if (req_cnt < mtbb_pkg::REQ_MIN) begin
          if (req_cnt == 4'd0) crc = mtbb_pkg::CRC_INIT;
          req_bytes[req_cnt] = r.data;
          if (req_cnt >= mtbb_pkg::CRC_START) crc = modbus_crc_update(crc, r.data);
          req_cnt++;
        end
        if (r.last) begin
          if (req_cnt >= mtbb_pkg::REQ_MIN && !waiting) begin
            regs = {req_bytes[10], req_bytes[11]};
            exp_len = 17'(int'(regs) * 2 + 3);
            frame[0] = mtbb_pkg::LINK_PREFIX_HI;
            frame[1] = mtbb_pkg::LINK_PREFIX_LO;
            frame[2] = seq;
            frame[3] = mtbb_pkg::LINK_CMD;
            frame[4] = mtbb_pkg::LINK_OP;
            for (int k = 0; k < 6; k++) frame[5 + k] = req_bytes[6 + k];
            frame[11] = crc[7:0];
            frame[12] = crc[15:8];
            for (int k = 0; k < 4; k++) hdr[k] = req_bytes[k];
            hdr[4] = exp_len[15:8];
            hdr[5] = exp_len[7:0];
            hdr[6] = req_bytes[6];
            hdr[7] = req_bytes[7];
            for (int k = 0; k < mtbb_pkg::FRAME_LEN; k++)
              push_result(mtbb_pkg::KIND_LINK, frame[k], k == mtbb_pkg::FRAME_LEN - 1,
                          mtbb_pkg::ST_READY);
            seq++;
            waiting = 1'b1;
            drain_on = 1'b0;
          end
          req_cnt = 4'd0;
          crc = mtbb_pkg::CRC_INIT;
        end
      end
      mtbb_pkg::FUNC_NOTIFY: begin
        drain_on = 1'b0;
        if (ntf_cnt < mtbb_pkg::NOTIFY_DEPTH) ntf[ntf_cnt[mtbb_pkg::NOTIFY_AW-1:0]] = r.data;
        if (ntf_cnt < mtbb_pkg::NOTIFY_MAX) ntf_cnt++;
        if (r.last) begin
          waiting = 1'b0;
          if (hdr[7] == mtbb_pkg::FUNC_WRITE_SINGLE) begin
            st = mtbb_pkg::ST_WRITE_CLOSE;
          end else if (int'(ntf_cnt) != int'(exp_len) + 7) begin
            if (len_err < mtbb_pkg::ERRORS_MAX) len_err++;
            st = (len_err > mtbb_pkg::ERROR_LIMIT) ? mtbb_pkg::ST_LEN_CLOSE
                                                   : mtbb_pkg::ST_LEN_RETRY;
          end else begin
            len_err = 3'd0;
            st = mtbb_pkg::ST_READY;
            drain_on = 1'b1;
            drain_pos = 9'd0;
          end
          ntf_cnt = 9'd0;
          push_result(mtbb_pkg::KIND_STATUS, 8'h00, 1'b1, st);
        end
      end
      mtbb_pkg::FUNC_DRAIN: begin
        if (drain_on) begin
          stored = int'(exp_len) + 7;
          lim = (stored < mtbb_pkg::NOTIFY_DEPTH) ? stored : mtbb_pkg::NOTIFY_DEPTH;
          total = 9 + int'(ntf[7]);
          if (drain_pos < mtbb_pkg::HEADER_LEN) begin
            v = hdr[drain_pos[2:0]];
          end else begin
            // clamp reads past the received bytes to the last stored one
            idx = 7 + int'(drain_pos) - mtbb_pkg::HEADER_LEN;
            if (idx >= lim) idx = lim - 1;
            v = ntf[idx[mtbb_pkg::NOTIFY_AW-1:0]];
          end
          if (int'(drain_pos) + 1 >= total) begin
            push_result(mtbb_pkg::KIND_REPLY, v, 1'b1, mtbb_pkg::ST_READY);
            drain_on = 1'b0;
            drain_pos = 9'd0;
          end else begin
            push_result(mtbb_pkg::KIND_REPLY, v, 1'b0, mtbb_pkg::ST_READY);
            drain_pos++;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [1:0] f, input logic [7:0] b, input logic e);
    bridge_req_t r;
    r.func = f;
    r.data = b;
    r.last = e;
    r.hold = 1'b0;
    pending_reqs.insert(pending_reqs.size(), r);
    queued_items++;
  endtask

  task automatic push_hold();
    bridge_req_t r;
    r.func = mtbb_pkg::FUNC_REQUEST;
    r.data = 8'h00;
    r.last = 1'b0;
    r.hold = 1'b1;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic send_request(input int nbytes, input logic [7:0] fcode,
                              input logic [15:0] regs);
    logic [7:0] b;
    for (int k = 0; k < nbytes; k++) begin
      case (k)
        7:       b = fcode;
        10:      b = regs[15:8];
        11:      b = regs[7:0];
        default: b = 8'($urandom_range(255));
      endcase
      push_item(mtbb_pkg::FUNC_REQUEST, b, k == nbytes - 1);
    end
  endtask

  task automatic send_notify(input int len, input logic [7:0] b7);
    for (int k = 0; k < len; k++)
      push_item(mtbb_pkg::FUNC_NOTIFY, (k == 7) ? b7 : 8'($urandom_range(255)),
                k == len - 1);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) push_item(mtbb_pkg::FUNC_DRAIN, 8'($urandom_range(255)),
                         1'($urandom_range(1)));
  endtask

  task automatic send_exchange();
    logic [7:0]  fcode;
    logic [15:0] regs;
    logic [7:0]  b7;
    int          nbytes;
    int          want_len;
    int          len;
    int          ticks;
    int          sel;
    sel = $urandom_range(9);
    fcode = (sel < 5) ? 8'd3 : (sel < 7) ? 8'd4 : (sel < 8) ? mtbb_pkg::FUNC_WRITE_SINGLE
          : 8'($urandom_range(255));
    sel = $urandom_range(19);
    regs = (sel == 0) ? 16'hFFFF : (sel == 1) ? 16'($urandom_range(65535))
         : 16'($urandom_range(12));
    nbytes = ($urandom_range(9) == 0) ? $urandom_range(13, 15) : 12;
    send_request(nbytes, fcode, regs);
    want_len = ((int'(regs) * 2 + 3) & 32'h1FFFF) + 7;
    // a second request while the reply is outstanding must be dropped
    if ($urandom_range(9) == 0)
      send_request(12, 8'($urandom_range(255)), 16'($urandom_range(65535)));
    if (want_len <= 60 && $urandom_range(9) < 8) len = want_len;
    else len = $urandom_range(1, 30);
    b7 = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
    send_notify(len, b7);
    if (fcode != mtbb_pkg::FUNC_WRITE_SINGLE && len == want_len) begin
      ticks = 9 + int'(b7);
      sel = $urandom_range(99);
      if (sel < 15) ticks = $urandom_range(1, ticks - 1);
      else if (sel < 30) ticks = ticks + $urandom_range(1, 3);
      send_ticks(ticks);
    end else if ($urandom_range(9) < 3) begin
      send_ticks($urandom_range(1, 2));
    end
  endtask

  task automatic build_stimulus();
    int sel;
    int n;
    // directed: unused selector, idle tick, short request, long request
    // with a count that wraps the expected length, clamped reply reads
    push_item(FUNC_UNUSED, 8'hFF, 1'b1);
    push_item(mtbb_pkg::FUNC_DRAIN, 8'h00, 1'b0);
    push_item(mtbb_pkg::FUNC_REQUEST, 8'h00, 1'b0);
    push_item(mtbb_pkg::FUNC_REQUEST, 8'hFF, 1'b1);
    send_request(14, 8'd3, 16'hFFFF);
    send_notify(8, 8'd2);
    send_ticks(11);
    push_hold();
    while (queued_items < 280) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        send_exchange();
      end else if (sel < 70) begin
        n = $urandom_range(1, 7);
        repeat (n) send_notify($urandom_range(1, 5), 8'($urandom_range(255)));
      end else if (sel < 80) begin
        send_request($urandom_range(1, 11), 8'($urandom_range(255)),
                     16'($urandom_range(65535)));
      end else if (sel < 88) begin
        n = $urandom_range(1, 6);
        repeat (n) push_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                             1'($urandom_range(1)));
      end else if (sel < 94) begin
        n = $urandom_range(1, 3);
        repeat (n) push_item(($urandom_range(1) == 0) ? mtbb_pkg::FUNC_DRAIN : FUNC_UNUSED,
                             8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        push_hold();
      end
    end
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // request acceptance and prediction
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_outputs(cur_req);
      req_taken = 1'b1;
      items_taken++;
    end
  end

  // result checking
  always @(posedge clk) begin
    cyc++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        $error("unexpected result: kind %0d byte %0d end %0d status %0d",
               kind, byte_out, run_end, status_code);
        errors++;
      end else begin
        got_want = expected_outputs.pop_front();
        check_field("kind", int'(got_want.kind), int'(kind));
        check_field("byte_out", int'(got_want.data), int'(byte_out));
        check_field("run_end", int'(got_want.last), int'(run_end));
        check_field("status_code", int'(got_want.status), int'(status_code));
        case (got_want.kind)
          mtbb_pkg::KIND_LINK:   link_bytes++;
          mtbb_pkg::KIND_REPLY:  reply_bytes++;
          mtbb_pkg::KIND_STATUS: status_seen[got_want.status]++;
          default: ;
        endcase
      end
    end
  end

  // request driver and result stall
  always @(negedge clk) begin
    if (!rst) begin
      out_stall <= !quiet && ($urandom_range(99) < 19);
      if (!in_valid || req_taken) begin
        req_taken = 1'b0;
        // hold off until every result in flight has drained
        if (pending_reqs.size() != 0 && pending_reqs[0].hold && expected_outputs.size() == 0)
          void'(pending_reqs.pop_front());
        if (pending_reqs.size() != 0 && !pending_reqs[0].hold &&
            (quiet || $urandom_range(99) >= 19)) begin
          cur_req = pending_reqs.pop_front();
          func <= cur_req.func;
          data_byte <= cur_req.data;
          is_last <= cur_req.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("Run covered %0d requests in: %0d link request bytes, %0d reply bytes out",
             items_taken, link_bytes, reply_bytes);
    $display("Status results: ready %0d, retry %0d, close %0d, write ack %0d",
             status_seen[mtbb_pkg::ST_READY], status_seen[mtbb_pkg::ST_LEN_RETRY],
             status_seen[mtbb_pkg::ST_LEN_CLOSE], status_seen[mtbb_pkg::ST_WRITE_CLOSE]);
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
